### src/base32_stream_encoder_defines.svh
// assertion macros for the base32 stream encoder
// no dependencies; included by files that carry concurrent checks
`ifndef BASE32_STREAM_ENCODER_DEFINES_SVH
`define BASE32_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define B32SE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("b32se check failed");
// consequent must hold in the cycle after the antecedent
`define B32SE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b32se check failed");
`else
`define B32SE_ASSERT_ALWAYS(lbl, prop)
`define B32SE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/b32se_pkg.sv
// shared widths, constants and the base32 alphabet lookup
// no dependencies
package b32se_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned GroupW  = 5;
  localparam int unsigned SymW    = 7;
  localparam int unsigned LeftW   = 4;
  localparam int unsigned LeftCntW = 3;
  localparam int unsigned SlotN   = 3;

  localparam logic [LeftCntW-1:0] LeftMax  = 3'd4;
  localparam logic [GroupW-1:0]   NumLetters = 5'd26;
  localparam logic [SymW-1:0]     AsciiA   = 7'h41;
  localparam logic [SymW-1:0]     Ascii2   = 7'h32;

  // 5-bit group to ascii: A-Z for 0..25, 2-7 for 26..31
  function automatic logic [SymW-1:0] b32_char(input logic [GroupW-1:0] grp);
    logic [SymW-1:0] ext;
    ext = {2'b00, grp};
    if (grp < NumLetters) begin
      b32_char = AsciiA + ext;
    end else begin
      b32_char = Ascii2 + ext - {2'b00, NumLetters};
    end
  endfunction

endpackage

### src/base32_stream_encoder.sv
// base32 stream encoder, unpadded, upper-case alphabet
// depends on b32se_pkg and base32_stream_encoder_defines.svh
//
// Takes one message byte per request on the slave stream (tlast marks the
// final byte) and emits ASCII base32 characters on the master stream, one
// per request, tlast on the final character of the message. No '=' padding
// is produced; a trailing partial group is zero-filled on the right. A byte
// is decoded in the cycle it is accepted into a three-entry slot buffer,
// which drains one character per cycle into the output register while it
// is free or the output is taken. A one-character byte can therefore be
// accepted every cycle while the output does not stall; a byte producing
// two or three characters holds off the next byte while they drain, so
// the rate is set by the single-character output port. The next byte is
// accepted in the cycle the buffer's last character moves to the output
// register, so input and output overlap. There is no clearing pass after reset.
`include "base32_stream_encoder_defines.svh"

module base32_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // final_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] symbol, [7] zero
  output logic       m_axis_tlast_o    // last_symbol
);
  import b32se_pkg::*;

  // leftover bits between bytes
  logic [LeftW-1:0]    lo_bits_q, lo_bits_d;
  logic [LeftCntW-1:0] lo_cnt_q, lo_cnt_d;

  // pending characters, slot 0 drains first
  logic [SymW-1:0] slot_sym_q [SlotN];
  logic [SymW-1:0] slot_sym_d [SlotN];
  logic [SlotN-1:0] slot_last_q, slot_last_d;
  logic [1:0] pend_cnt_q, pend_cnt_d;

  // output register
  logic            out_vld_q, out_vld_d;
  logic [SymW-1:0] out_sym_q, out_sym_d;
  logic            out_last_q, out_last_d;

  logic in_acc, out_load;

  // decode of the incoming byte
  logic [LeftCntW-1:0] cnt;
  logic [3:0]          total;
  logic [11:0]         acc;
  logic                two_full, has_pad, fin;
  logic [3:0]          sh1, sh2;
  logic [2:0]          rem;
  logic [11:0]         acc_sh1, acc_sh2, acc_pad;
  logic [GroupW-1:0]   grp1, grp2, grp_pad;
  logic [LeftW-1:0]    rem_mask;

  always_comb begin
    fin      = s_axis_tlast_i;
    cnt      = (lo_cnt_q > LeftMax) ? LeftMax : lo_cnt_q;
    total    = {1'b0, cnt} + 4'd8;
    acc      = {lo_bits_q, s_axis_tdata_i};
    two_full = (total >= 4'd10);
    sh1      = total - 4'd5;
    sh2      = two_full ? (total - 4'd10) : 4'd0;
    rem      = two_full ? 3'(total - 4'd10) : 3'(total - 4'd5);
    acc_sh1  = acc >> sh1;
    acc_sh2  = acc >> sh2;
    // zero-fill the trailing partial group on the right
    acc_pad  = acc << (3'd5 - rem);
    grp1     = acc_sh1[GroupW-1:0];
    grp2     = acc_sh2[GroupW-1:0];
    grp_pad  = acc_pad[GroupW-1:0];
    has_pad  = fin && (rem != 3'd0);
    rem_mask = 4'((5'd1 << rem) - 5'd1);
  end

  // a character leaves the buffer whenever the output register frees up
  assign out_load        = (pend_cnt_q != 2'd0) && (!out_vld_q || m_axis_tready_i);
  // take a byte once the buffer is empty after this cycle
  assign s_axis_tready_o = (pend_cnt_q == 2'd0) || ((pend_cnt_q == 2'd1) && out_load);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    lo_bits_d   = lo_bits_q;
    lo_cnt_d    = lo_cnt_q;
    slot_sym_d  = slot_sym_q;
    slot_last_d = slot_last_q;
    pend_cnt_d  = pend_cnt_q;
    out_vld_d   = out_vld_q;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;

    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    if (out_load) begin
      out_vld_d      = 1'b1;
      out_sym_d      = slot_sym_q[0];
      out_last_d     = slot_last_q[0];
      slot_sym_d[0]  = slot_sym_q[1];
      slot_sym_d[1]  = slot_sym_q[2];
      slot_last_d[0] = slot_last_q[1];
      slot_last_d[1] = slot_last_q[2];
      pend_cnt_d     = pend_cnt_q - 2'd1;
    end

    if (in_acc) begin
      slot_sym_d[0]  = b32_char(grp1);
      slot_last_d[0] = fin && !two_full && !has_pad;
      slot_sym_d[1]  = two_full ? b32_char(grp2) : b32_char(grp_pad);
      slot_last_d[1] = fin && (two_full ? !has_pad : 1'b1);
      slot_sym_d[2]  = b32_char(grp_pad);
      slot_last_d[2] = 1'b1;
      pend_cnt_d     = 2'd1 + {1'b0, two_full} + {1'b0, has_pad};
      if (fin) begin
        lo_bits_d = '0;
        lo_cnt_d  = '0;
      end else begin
        lo_bits_d = acc[LeftW-1:0] & rem_mask;
        lo_cnt_d  = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_bits_q   <= '0;
      lo_cnt_q    <= '0;
      pend_cnt_q  <= '0;
      out_vld_q   <= 1'b0;
      slot_last_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      lo_bits_q   <= lo_bits_d;
      lo_cnt_q    <= lo_cnt_d;
      pend_cnt_q  <= pend_cnt_d;
      out_vld_q   <= out_vld_d;
      slot_last_q <= slot_last_d;
      out_last_q  <= out_last_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    slot_sym_q <= slot_sym_d;
    out_sym_q  <= out_sym_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_sym_q};
  assign m_axis_tlast_o  = out_last_q;

  // every accepted byte leaves at least one character behind
  `B32SE_ASSERT_NEXT(a_byte_yields_char, in_acc, pend_cnt_q != 2'd0)
  // a final byte leaves no carried bits for the next message
  `B32SE_ASSERT_NEXT(a_final_clears, in_acc && s_axis_tlast_i,
                     (lo_cnt_q == 3'd0) && (lo_bits_q == 4'd0))
  // carried bit count never exceeds a partial group
  `B32SE_ASSERT_ALWAYS(a_left_bound, lo_cnt_q <= LeftMax)

endmodule
